### sv/indexed_binary_heap_top_defines.svh
// Assertion macros shared by the heap RTL
`ifndef INDEXED_BINARY_HEAP_TOP_DEFINES_SVH
`define INDEXED_BINARY_HEAP_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define IBH_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication
`define IBH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

### sv/ibh_pkg.sv
// ----------------------------------------------------------------------------
// ibh_pkg
// Shared types, codes and defaults for the indexed binary heap.
// ----------------------------------------------------------------------------
`default_nettype none
package ibh_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int NUM_IDS      = 16;
    localparam int ID_BITS      = 4;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_START   = 4'd1,  // latch request, compute status
        OP_INS     = 4'd2,  // commit insert: bump fill, mark id present
        OP_RD_HOLE = 4'd3,  // read entry being removed
        OP_RD_TAIL = 4'd4,  // capture removed entry, read tail entry
        OP_LD_TAIL = 4'd5,  // load tail entry as moving entry
        OP_UP_RD   = 4'd6,  // read parent
        OP_UP_CMP  = 4'd7,  // compare with parent, move parent down or stop
        OP_DN_RDL  = 4'd8,  // read left child
        OP_DN_RDR  = 4'd9,  // capture left child, read right child
        OP_DN_CMP  = 4'd10, // compare with children, move child up or stop
        OP_WR_FIN  = 4'd11, // write moving entry at final slot
        OP_RD_TOP  = 4'd12, // read slot zero
        OP_FINISH  = 4'd13  // load result register
    } op_t;

    typedef struct packed {
        logic bad;        // request rejected or ignored
        logic is_ins;
        logic need_move;  // hole below tail after removal
        logic at_root;    // cursor at slot zero
        logic no_left;    // cursor has no left child
        logic up_stop;    // entry stays below its parent
        logic dn_stop;    // entry stays above its children
    } dp_status_t;
endpackage
`default_nettype wire

### sv/indexed_binary_heap_top.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_top
// Indexed binary-heap priority queue with delete by id.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = kind, tdata = {item_key, item_id}.
//   m_axis returns one result per request, tdata packed from the lowest bit:
//   status, removed_id, removed_key, top_valid, top_id, top_key, count.
//   cfg_we / cfg_wdata write max_first (0 min at top, 1 max at top) while idle.
//   One request is handled at a time: s_axis_tready is high only while the
//   sequencer is idle. A rejected or ignored request goes from the check
//   straight to the top read and the result load; an insert bumps the fill,
//   walks up past each parent that must move and writes its entry; a delete
//   or pop reads the hole and the tail, then, when the hole lies below the
//   tail, walks up, walks down past each child that must move and writes it.
//   Each level is a RAM read, a compare and a write on the single heap RAM
//   port.
//   The result sits in an output register; when the receiver stalls, the
//   sequencer holds in its final state until the register is free.
//   Reset clears present flags, the fill count and max_first; heap slots
//   need no clearing pass since only filled slots are read.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_binary_heap_top #(
    parameter int CAPACITY = ibh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ibh_pkg::KEY_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,  // kind
    input  wire logic [39:0] s_axis_tdata,  // item_id[3:0], item_key[35:4], pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata   // status, removed_id, removed_key,
                                            // top_valid, top_id, top_key, count, pad
);
    logic max_first_reg;
    logic idle, res_load, in_fire, vld_reg;
    ibh_pkg::op_t        op;
    ibh_pkg::dp_status_t st;
    logic [2:0]  r_status;
    logic [3:0]  r_rid, r_tid;
    logic [31:0] r_rkey, r_tkey;
    logic        r_tvalid;
    logic [4:0]  r_count;

    // hold max_first until rewritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) max_first_reg <= 1'b0;
        else if (cfg_we) max_first_reg <= cfg_wdata;
    end

    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    ibh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(vld_reg && !m_axis_tready), .st(st), .op(op),
        .idle(idle), .res_load(res_load)
    );

    ibh_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .max_first(max_first_reg), .op(op),
        .req_kind(s_axis_tuser), .req_id(s_axis_tdata[3:0]),
        .req_key(s_axis_tdata[35:4]), .st(st),
        .res_status(r_status), .res_rid(r_rid), .res_rkey(r_rkey),
        .res_tvalid(r_tvalid), .res_tid(r_tid), .res_tkey(r_tkey),
        .res_count(r_count)
    );

    // advance output valid: set on load, drop on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= 1'b0;
        else if (res_load) vld_reg <= 1'b1;
        else if (m_axis_tready) vld_reg <= 1'b0;
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata = {7'd0, r_count, r_tkey, r_tid, r_tvalid, r_rkey, r_rid, r_status};
endmodule
`default_nettype wire

### sv/ibh_ram.sv
// ----------------------------------------------------------------------------
// ibh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ibh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### sv/ibh_datapath.sv
// ----------------------------------------------------------------------------
// ibh_datapath
// Heap memory, id tables, cursor and comparators.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_binary_heap_top_defines.svh"
module ibh_datapath #(
    parameter int CAPACITY = ibh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ibh_pkg::KEY_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               max_first,
    input  wire ibh_pkg::op_t       op,
    input  wire logic [1:0]         req_kind,
    input  wire logic [3:0]         req_id,
    input  wire logic [31:0]        req_key,
    output ibh_pkg::dp_status_t     st,
    output logic [2:0]              res_status,
    output logic [3:0]              res_rid,
    output logic [31:0]             res_rkey,
    output logic                    res_tvalid,
    output logic [3:0]              res_tid,
    output logic [31:0]             res_tkey,
    output logic [4:0]              res_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;
    localparam int IW = ibh_pkg::ID_BITS;
    localparam int EW = IW + KEY_BITS;

    logic [1:0]                  kind_reg;
    logic [IW-1:0]               id_reg;
    logic [2:0]                  status_reg;
    logic                        nop_reg;
    logic [IW-1:0]               rid_reg;
    logic [KEY_BITS-1:0]         rkey_reg;
    logic [CW-1:0]               fill_reg;
    logic [ibh_pkg::NUM_IDS-1:0] present_reg;
    logic [AW-1:0]               slot_reg [ibh_pkg::NUM_IDS];
    logic [AW-1:0]               pos_reg;
    logic [EW-1:0]               cur_reg, aux_reg;

    logic                we;
    logic [AW-1:0]       addr;
    logic [EW-1:0]       wdata, rdata;

    ibh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // true when key a may stay where it is relative to key b
    function automatic logic stays(input logic mf, input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
        return mf ? (a <= b) : (a >= b);
    endfunction

    logic [LW-1:0]       lch, rch;
    logic [AW-1:0]       par, dpos;
    logic [KEY_BITS-1:0] ck, ak, rk, bk;
    logic [IW-1:0]       cid, aid, rd_id;
    logic                l_ok, r_ok, take_l, take_r, up_stop;

    assign lch   = {1'b0, pos_reg, 1'b1};
    assign rch   = {1'b0, pos_reg, 1'b0} + LW'(2);
    assign par   = (pos_reg - AW'(1)) >> 1;
    assign ck    = cur_reg[KEY_BITS-1:0];
    assign ak    = aux_reg[KEY_BITS-1:0];
    assign rk    = rdata[KEY_BITS-1:0];
    assign cid   = cur_reg[EW-1 -: IW];
    assign aid   = aux_reg[EW-1 -: IW];
    assign rd_id = rdata[EW-1 -: IW];
    assign l_ok  = lch < LW'(fill_reg);
    assign r_ok  = rch < LW'(fill_reg);
    assign dpos  = slot_reg[req_id];

    // right child wins over the left one or the entry itself on a tie
    always_comb
    begin
        take_l  = l_ok && stays(max_first, ck, ak);
        bk      = take_l ? ak : ck;
        take_r  = r_ok && stays(max_first, bk, rk);
        up_stop = stays(max_first, ck, rk);
    end

    always_comb
    begin
        st.bad       = nop_reg || (status_reg != ibh_pkg::ST_OK);
        st.is_ins    = kind_reg == ibh_pkg::KIND_INSERT;
        st.need_move = CW'(pos_reg) < fill_reg;
        st.at_root   = pos_reg == '0;
        st.no_left   = !l_ok;
        st.up_stop   = up_stop;
        st.dn_stop   = !(take_l || take_r);
    end

    always_comb
    begin
        we    = 1'b0;
        addr  = '0;
        wdata = cur_reg;
        unique case (op)
            ibh_pkg::OP_RD_HOLE: addr = pos_reg;
            ibh_pkg::OP_RD_TAIL: addr = AW'(fill_reg - CW'(1));
            ibh_pkg::OP_UP_RD:   addr = par;
            ibh_pkg::OP_UP_CMP:
            begin
                if (!up_stop)
                begin
                    we = 1'b1; addr = pos_reg; wdata = rdata;
                end
            end
            ibh_pkg::OP_DN_RDL:  addr = AW'(lch);
            ibh_pkg::OP_DN_RDR:  addr = r_ok ? AW'(rch) : AW'(lch);
            ibh_pkg::OP_DN_CMP:
            begin
                if (take_r)
                begin
                    we = 1'b1; addr = pos_reg; wdata = rdata;
                end
                else if (take_l)
                begin
                    we = 1'b1; addr = pos_reg; wdata = aux_reg;
                end
            end
            ibh_pkg::OP_WR_FIN:
            begin
                we = 1'b1; addr = pos_reg; wdata = cur_reg;
            end
            ibh_pkg::OP_RD_TOP:  addr = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            present_reg <= '0;
        end
        else if (op == ibh_pkg::OP_INS)
        begin
            fill_reg <= fill_reg + CW'(1);
            present_reg[id_reg] <= 1'b1;
        end
        else if (op == ibh_pkg::OP_RD_TAIL)
        begin
            fill_reg <= fill_reg - CW'(1);
            present_reg[rd_id] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            ibh_pkg::OP_START:
            begin
                kind_reg   <= req_kind;
                id_reg     <= req_id;
                rid_reg    <= '0;
                rkey_reg   <= '0;
                nop_reg    <= 1'b0;
                status_reg <= ibh_pkg::ST_OK;
                if (req_kind == ibh_pkg::KIND_INSERT)
                begin
                    if (present_reg[req_id])
                        status_reg <= ibh_pkg::ST_PRESENT;
                    else if (fill_reg >= CW'(CAPACITY))
                        status_reg <= ibh_pkg::ST_FULL;
                    pos_reg <= AW'(fill_reg);
                    cur_reg <= {req_id, KEY_BITS'(req_key)};
                end
                else if (req_kind == ibh_pkg::KIND_DELETE)
                begin
                    if (!present_reg[req_id] || CW'(dpos) >= fill_reg)
                        status_reg <= ibh_pkg::ST_ABSENT;
                    pos_reg <= dpos;
                end
                else if (req_kind == ibh_pkg::KIND_POP)
                begin
                    if (fill_reg == '0)
                        status_reg <= ibh_pkg::ST_EMPTY;
                    pos_reg <= '0;
                end
                else
                    nop_reg <= 1'b1;
            end
            ibh_pkg::OP_RD_TAIL:
            begin
                rid_reg  <= rd_id;
                rkey_reg <= rk;
            end
            ibh_pkg::OP_LD_TAIL: cur_reg <= rdata;
            ibh_pkg::OP_UP_CMP:
            begin
                // drop the parent into the hole and climb
                if (!up_stop)
                begin
                    slot_reg[rd_id] <= pos_reg;
                    pos_reg <= par;
                end
            end
            ibh_pkg::OP_DN_RDR:  aux_reg <= rdata;
            ibh_pkg::OP_DN_CMP:
            begin
                // lift the chosen child into the hole and descend
                if (take_r)
                begin
                    slot_reg[rd_id] <= pos_reg;
                    pos_reg <= AW'(rch);
                end
                else if (take_l)
                begin
                    slot_reg[aid] <= pos_reg;
                    pos_reg <= AW'(lch);
                end
            end
            ibh_pkg::OP_WR_FIN:  slot_reg[cid] <= pos_reg;
            ibh_pkg::OP_FINISH:
            begin
                res_status <= status_reg;
                res_rid    <= rid_reg;
                res_rkey   <= 32'(rkey_reg);
                res_count  <= 5'(fill_reg);
                res_tvalid <= fill_reg != '0;
                res_tid    <= (fill_reg != '0) ? rd_id : '0;
                res_tkey   <= (fill_reg != '0) ? 32'(rk) : '0;
            end
            default: ;
        endcase
    end

    `IBH_ASSERT_IMP(a_fill_cap, clk, rst_n, 1'b1, fill_reg <= CW'(CAPACITY),
        "fill count beyond capacity")
    `IBH_ASSERT_IMP(a_count_pop, clk, rst_n, 1'b1,
        $countones(present_reg) == int'(fill_reg), "present flags disagree with fill")
    `IBH_ASSERT_NEXT(a_fin_top, clk, rst_n, op == ibh_pkg::OP_FINISH,
        res_tvalid == (res_count != '0), "top valid disagrees with count")
endmodule
`default_nettype wire

### sv/ibh_ctrl.sv
// ----------------------------------------------------------------------------
// ibh_ctrl
// Sequencer for insert, delete and pop requests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_binary_heap_top_defines.svh"
module ibh_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic                out_busy,
    input  wire ibh_pkg::dp_status_t st,
    output ibh_pkg::op_t             op,
    output logic                     idle,
    output logic                     res_load
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CHK   = 12'b000000000010,
        S_RM1   = 12'b000000000100,
        S_RM2   = 12'b000000001000,
        S_UPRD  = 12'b000000010000,
        S_UPCMP = 12'b000000100000,
        S_DNRDL = 12'b000001000000,
        S_DNRDR = 12'b000010000000,
        S_DNCMP = 12'b000100000000,
        S_WRFIN = 12'b001000000000,
        S_TOP   = 12'b010000000000,
        S_FIN   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign idle     = state_reg == S_IDLE;
    assign res_load = state_reg == S_FIN && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        op = ibh_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    op = ibh_pkg::OP_START; state_next = S_CHK;
                end
            S_CHK:
            begin
                if (st.bad)
                    state_next = S_TOP;
                else if (st.is_ins)
                begin
                    op = ibh_pkg::OP_INS; state_next = S_UPRD;
                end
                else
                begin
                    op = ibh_pkg::OP_RD_HOLE; state_next = S_RM1;
                end
            end
            S_RM1:
            begin
                op = ibh_pkg::OP_RD_TAIL; state_next = S_RM2;
            end
            S_RM2:
            begin
                op = ibh_pkg::OP_LD_TAIL;
                state_next = st.need_move ? S_UPRD : S_TOP;
            end
            S_UPRD:
            begin
                if (st.at_root)
                    state_next = st.is_ins ? S_WRFIN : S_DNRDL;
                else
                begin
                    op = ibh_pkg::OP_UP_RD; state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                op = ibh_pkg::OP_UP_CMP;
                if (st.up_stop)
                    state_next = st.is_ins ? S_WRFIN : S_DNRDL;
                else
                    state_next = S_UPRD;
            end
            S_DNRDL:
            begin
                if (st.no_left)
                    state_next = S_WRFIN;
                else
                begin
                    op = ibh_pkg::OP_DN_RDL; state_next = S_DNRDR;
                end
            end
            S_DNRDR:
            begin
                op = ibh_pkg::OP_DN_RDR; state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                op = ibh_pkg::OP_DN_CMP;
                state_next = st.dn_stop ? S_WRFIN : S_DNRDL;
            end
            S_WRFIN:
            begin
                op = ibh_pkg::OP_WR_FIN; state_next = S_TOP;
            end
            S_TOP:
            begin
                op = ibh_pkg::OP_RD_TOP; state_next = S_FIN;
            end
            S_FIN:
                if (!out_busy)
                begin
                    op = ibh_pkg::OP_FINISH; state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    `IBH_ASSERT_NEXT(a_start, clk, rst_n, state_reg == S_IDLE && in_fire,
        state_reg == S_CHK, "accepted request not started")
    `IBH_ASSERT_IMP(a_load, clk, rst_n, res_load, !out_busy, "result overwritten")
    `IBH_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
endmodule
`default_nettype wire
